/* src/ftg_pkg.sv */
`default_nettype none

package ftg_pkg;

	localparam int LIGHT_WIDTH  = 24;
	localparam int GAIN_WIDTH   = 16;
	localparam int BYTE_WIDTH   = 8;
	localparam int SERIES_TERMS = 20;
	localparam int SQUARINGS    = 4;

	localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd4096;

	// input product, two stages per series term, fold, squarings, complement, byte search
	localparam int LANE_LAT = 1 + 2 * (SERIES_TERMS - 1) + 1 + SQUARINGS + 1 + BYTE_WIDTH;
	localparam int CORE_LAT = LANE_LAT + 1;

	typedef struct packed {
		logic signed [LIGHT_WIDTH-1:0] red_light;
		logic signed [LIGHT_WIDTH-1:0] green_light;
		logic signed [LIGHT_WIDTH-1:0] blue_light;
	} pixel_t;

	typedef struct packed {
		logic [BYTE_WIDTH-1:0] blue_byte;
		logic [BYTE_WIDTH-1:0] green_byte;
		logic [BYTE_WIDTH-1:0] red_byte;
	} tone_t;

	typedef struct packed {
		logic [31:0] term;
		logic [31:0] arg;
		logic [32:0] acc;
		logic        full;
	} ser_t;

	typedef logic [31:0] thr_tab_t [256];

	// smallest y with y^5 >= k^11 * 2^72
	function automatic thr_tab_t gamma_thr_tab();
		thr_tab_t     tab;
		logic [191:0] target;
		logic [191:0] cand;
		logic [191:0] pw;
		logic [32:0]  m;
		int           k;
		int           b;
		int           i;
		tab[0] = 32'd0;
		for (k = 1; k < 256; k++) begin
			target = 192'd1;
			for (i = 0; i < 11; i++)
				target = target * 192'(k);
			target = target << 72;
			m = 33'd0;
			for (b = 31; b >= 0; b--) begin
				cand = 192'(m) | (192'd1 << b);
				pw = cand;
				for (i = 0; i < 4; i++)
					pw = pw * cand;
				if (pw < target)
					m = 33'(cand);
			end
			tab[k] = 32'(m + 33'd1);
		end
		return tab;
	endfunction

	localparam thr_tab_t GAMMA_THR = gamma_thr_tab();

endpackage

`default_nettype wire

/* src/film_tonemap_gamma_rgb_core.sv */
// film tone mapper with gamma 2.2, one rgb pixel per clock
// input: pixel (signed q8.16 red, green, blue light) is taken at a rising edge
//   with start high and busy low; busy is always low, a pixel may come every cycle
// output: result holds blue, green, red bytes for exactly one cycle, marked by done;
//   the receiver takes it in that cycle and cannot stall the block
// pipeline: the input product, the 19 series terms of the exponential, two stages
//   each, the fold of the last term, the four squarings, the complement, the eight
//   step search of the gamma table and the merged result register
// throughput: one pixel per cycle, three channel lanes run side by side
// configuration: gain_we writes gain_wdata into the unsigned q4.12 exposure gain;
//   write it only while no pixel is in flight
// reset: arst_n low clears the in-flight marks and sets the gain to 1.0;
//   results of pixels in flight at reset are dropped
`default_nettype none

module film_tonemap_gamma_rgb_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  ftg_pkg::pixel_t                  pixel,
	input  logic                             gain_we,
	input  logic [ftg_pkg::GAIN_WIDTH-1:0]   gain_wdata,
	output logic                             done,
	output ftg_pkg::tone_t                   result
);

	localparam int LAT = ftg_pkg::LANE_LAT;

	logic [ftg_pkg::GAIN_WIDTH-1:0] gain_q;
	logic [LAT-1:0]                 vld_q;
	logic                           done_q;
	ftg_pkg::tone_t                 result_q;
	logic [ftg_pkg::BYTE_WIDTH-1:0] tone_r;
	logic [ftg_pkg::BYTE_WIDTH-1:0] tone_g;
	logic [ftg_pkg::BYTE_WIDTH-1:0] tone_b;
	logic                           xfer;

	assign busy = 1'b0;
	assign xfer = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ftg_pkg::GAIN_RESET;
		end else if (gain_we) begin
			gain_q <= gain_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[LAT-2:0], xfer};
			done_q <= vld_q[LAT-1];
		end
	end

	ftg_lane u_lane_r (.clk(clk), .gain(gain_q), .light(pixel.red_light),   .tone(tone_r));
	ftg_lane u_lane_g (.clk(clk), .gain(gain_q), .light(pixel.green_light), .tone(tone_g));
	ftg_lane u_lane_b (.clk(clk), .gain(gain_q), .light(pixel.blue_light),  .tone(tone_b));

	// merge lanes into the bgr result
	always_ff @(posedge clk) begin
		result_q.blue_byte  <= tone_b;
		result_q.green_byte <= tone_g;
		result_q.red_byte   <= tone_r;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

/* src/ftg_term.sv */
`default_nettype none

module ftg_term #(
	parameter int K = 2
) (
	input  logic            clk,
	input  ftg_pkg::ser_t   din,
	output ftg_pkg::ser_t   dout
);

	localparam int          SH  = 32 + $clog2(K);
	localparam logic [32:0] MAG = 33'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));
	localparam bit          SUB = ((K - 1) % 2) == 1;

	ftg_pkg::ser_t a_s1;
	ftg_pkg::ser_t b_s2;
	logic [63:0]   tr;
	logic [64:0]   qm;

	assign tr = 64'(din.term) * 64'(din.arg);

	// multiply by the previous term, fold the previous term into the sum
	always_ff @(posedge clk) begin
		a_s1.term <= tr[63:32];
		a_s1.arg  <= din.arg;
		a_s1.acc  <= SUB ? din.acc - 33'(din.term) : din.acc + 33'(din.term);
		a_s1.full <= din.full;
	end

	// exact divide by K through a reciprocal
	assign qm = 65'(a_s1.term) * 65'(MAG);

	always_ff @(posedge clk) begin
		b_s2.term <= 32'(qm >> SH);
		b_s2.arg  <= a_s1.arg;
		b_s2.acc  <= a_s1.acc;
		b_s2.full <= a_s1.full;
	end

	assign dout = b_s2;

endmodule

`default_nettype wire

/* src/ftg_lane.sv */
`default_nettype none

module ftg_lane (
	input  logic                                      clk,
	input  logic        [ftg_pkg::GAIN_WIDTH-1:0]     gain,
	input  logic signed [ftg_pkg::LIGHT_WIDTH-1:0]    light,
	output logic        [ftg_pkg::BYTE_WIDTH-1:0]     tone
);

	localparam int LW = ftg_pkg::LIGHT_WIDTH;
	localparam int BW = ftg_pkg::BYTE_WIDTH;
	localparam int NT = ftg_pkg::SERIES_TERMS;
	localparam int NS = ftg_pkg::SQUARINGS;
	localparam int XW = (ftg_pkg::GAIN_WIDTH + LW > 33) ? ftg_pkg::GAIN_WIDTH + LW : 33;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	typedef struct packed {
		logic [32:0] e;
		logic        full;
	} sq_t;

	typedef struct packed {
		logic [31:0]   y;
		logic [BW-1:0] k;
		logic          full;
	} gs_t;

	logic          nonpos;
	logic [XW-1:0] x_s1;
	ftg_pkg::ser_t chain [2:NT+1];
	sq_t           sq_s [NS+1];
	gs_t           gs_s [BW+1];
	logic [32:0]   ydiff;

	assign nonpos = light[LW-1] | (light == '0);

	always_ff @(posedge clk) begin
		x_s1 <= nonpos ? '0 : XW'(gain) * XW'(light[LW-2:0]);
	end

	assign chain[2] = '{term: x_s1[31:0], arg: x_s1[31:0], acc: ONE_Q32,
	                    full: |x_s1[XW-1:32]};

	for (genvar g = 2; g <= NT; g++) begin : g_term
		ftg_term #(.K(g)) u_term (
			.clk  (clk),
			.din  (chain[g]),
			.dout (chain[g+1])
		);
	end

	// last term into the sum
	always_ff @(posedge clk) begin
		sq_s[0].e    <= ((NT % 2) == 0) ? chain[NT+1].acc + 33'(chain[NT+1].term)
		                                : chain[NT+1].acc - 33'(chain[NT+1].term);
		sq_s[0].full <= chain[NT+1].full;
	end

	for (genvar g = 0; g < NS; g++) begin : g_sq
		logic [63:0] sqp;
		assign sqp = 64'(sq_s[g].e[31:0]) * 64'(sq_s[g].e[31:0]);
		always_ff @(posedge clk) begin
			sq_s[g+1].e    <= sq_s[g].e[32] ? sq_s[g].e : {1'b0, sqp[63:32]};
			sq_s[g+1].full <= sq_s[g].full;
		end
	end

	assign ydiff = ONE_Q32 - sq_s[NS].e;

	always_ff @(posedge clk) begin
		gs_s[0].y    <= ydiff[31:0];
		gs_s[0].k    <= '0;
		gs_s[0].full <= sq_s[NS].full | ydiff[32];
	end

	// binary search of the gamma threshold table, one bit per stage
	for (genvar g = 0; g < BW; g++) begin : g_gam
		localparam logic [BW-1:0] BIT = BW'(1 << (BW - 1 - g));
		logic [BW-1:0] cand;
		logic          take;
		assign cand = gs_s[g].k | BIT;
		assign take = gs_s[g].y >= ftg_pkg::GAMMA_THR[cand];
		always_ff @(posedge clk) begin
			gs_s[g+1].y    <= gs_s[g].y;
			gs_s[g+1].k    <= take ? cand : gs_s[g].k;
			gs_s[g+1].full <= gs_s[g].full;
		end
	end

	assign tone = gs_s[BW].full ? '1 : gs_s[BW].k;

endmodule

`default_nettype wire

/* src/ftg_check.sv */
`default_nettype none

module ftg_check (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  ftg_pkg::pixel_t pixel,
	input  logic            done,
	input  ftg_pkg::tone_t  result
);

	localparam int LAT = ftg_pkg::CORE_LAT;
	localparam int CW  = $clog2(LAT + 1);
	localparam int LW  = ftg_pkg::LIGHT_WIDTH;

	logic [CW-1:0] since_q;
	logic          warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
		end else if (since_q != CW'(LAT)) begin
			since_q <= since_q + CW'(1);
		end
	end

	assign warm = since_q == CW'(LAT);

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		!warm |-> !done)
		else $error("result strobe before any transfer could finish");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> done == $past(start && !busy, LAT))
		else $error("result strobe does not match an input transfer");

	a_red_dark: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done && $past(pixel.red_light[LW-1] || pixel.red_light == '0, LAT)
		|-> result.red_byte == '0)
		else $error("dark red light gave a nonzero byte");

	a_blue_dark: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done && $past(pixel.blue_light[LW-1] || pixel.blue_light == '0, LAT)
		|-> result.blue_byte == '0)
		else $error("dark blue light gave a nonzero byte");

endmodule

bind film_tonemap_gamma_rgb_core ftg_check u_ftg_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.result (result)
);

`default_nettype wire
